### sv/rlsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlsf_pkg
// Shared types and constants of the radio link search controller.
// ----------------------------------------------------------------------------
package rlsf_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CHAN_W     = 7;
  localparam int unsigned CODE_W     = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SEARCH_TICKS  = 2'd0,
    CFG_ANSWER_TICKS  = 2'd1,
    CFG_STANDBY_TICKS = 2'd2,
    CFG_TOP_CHANNEL   = 2'd3
  } cfg_addr_t;

  typedef enum logic [5:0] {
    ST_STANDBY = 6'b000001,
    ST_WAIT_TX = 6'b000010,
    ST_HOP     = 6'b000100,
    ST_PROBE   = 6'b001000,
    ST_BEACON  = 6'b010000,
    ST_WAIT_AN = 6'b100000
  } ctrl_state_t;

  localparam logic [CODE_W-1:0] CODE_STANDBY = 3'd0;
  localparam logic [CODE_W-1:0] CODE_WAIT_TX = 3'd1;
  localparam logic [CODE_W-1:0] CODE_HOP     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_PROBE   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BEACON  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_WAIT_AN = 3'd5;

  localparam logic [PERIOD_W-1:0] SEARCH_TICKS_RST  = 16'd1000;
  localparam logic [PERIOD_W-1:0] ANSWER_TICKS_RST  = 16'd100;
  localparam logic [PERIOD_W-1:0] STANDBY_TICKS_RST = 16'd5000;
  localparam logic [CHAN_W-1:0]   TOP_CHANNEL_RST   = 7'd127;

  function automatic logic [CODE_W-1:0] state_code(input ctrl_state_t st);
    logic [CODE_W-1:0] code;
    unique case (st)
      ST_STANDBY: code = CODE_STANDBY;
      ST_WAIT_TX: code = CODE_WAIT_TX;
      ST_HOP:     code = CODE_HOP;
      ST_PROBE:   code = CODE_PROBE;
      ST_BEACON:  code = CODE_BEACON;
      ST_WAIT_AN: code = CODE_WAIT_AN;
      default:    code = CODE_HOP;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

### sv/rlsf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlsf interfaces
// Poll, result and configuration channels of the radio link search controller.
// ----------------------------------------------------------------------------
interface rlsf_in_if;
  logic valid;
  logic ready;
  logic time_tick;
  logic line_level;
  logic rx_ready;
  logic rx_checksum_ok;
  logic rx_status_request;
  logic tx_busy;

  modport source (output valid, time_tick, line_level, rx_ready, rx_checksum_ok,
                  rx_status_request, tx_busy, input ready);
  modport sink (input valid, time_tick, line_level, rx_ready, rx_checksum_ok,
                rx_status_request, tx_busy, output ready);
endinterface

interface rlsf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] channel;
  logic       channel_changed;
  logic       send_beacon;
  logic       send_status;
  logic       status_on_line;
  logic       link_up;
  logic [2:0] fsm_state;

  modport source (output valid, channel, channel_changed, send_beacon, send_status,
                  status_on_line, link_up, fsm_state, input ready);
  modport sink (input valid, channel, channel_changed, send_beacon, send_status,
                status_on_line, link_up, fsm_state, output ready);
endinterface

interface rlsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### sv/radio_link_search_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radio_link_search_fsm
// Six-state link controller that hops radio channels, sends beacons and keeps
// the link in standby until a timeout.
// ----------------------------------------------------------------------------
// Each transaction on in_ch is one poll of the control loop. The poll is
// evaluated against the controller state in the accepting cycle and its result
// is loaded into the output register, so it appears on out_ch in the cycle after
// acceptance. One poll can be accepted every cycle unless out_ch stalls.
// The output register acts as the only buffer: in_ch.ready is high while the
// register is empty or is being drained in the same cycle. When the receiver
// stalls, the pending result holds and in_ch stops after one result waits.
// cfg_ch writes the four period and channel registers; it is always ready and
// is meant to be used only while no poll is in flight.
// Reset puts the controller in the hop state on channel 0 with all timers at
// zero, restores the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module radio_link_search_fsm
  import rlsf_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rlsf_in_if.sink    in_ch,
  rlsf_out_if.source out_ch,
  rlsf_cfg_if.sink   cfg_ch
);

  localparam int unsigned CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

  logic [PERIOD_W-1:0]   search_ticks_r, answer_ticks_r, standby_ticks_r;
  logic [CHAN_W-1:0]     top_channel_r;

  ctrl_state_t           state_r, state_nxt;
  logic [CHAN_W-1:0]     chan_r, chan_nxt;
  logic [TIMER_BITS-1:0] search_cnt_r, search_cnt_nxt;
  logic [TIMER_BITS-1:0] answer_cnt_r, answer_cnt_nxt;
  logic [TIMER_BITS-1:0] standby_cnt_r, standby_cnt_nxt;
  logic                  last_line_r, last_line_nxt;

  logic                  out_valid_r;
  logic [CHAN_W-1:0]     out_chan_r;
  logic                  out_chg_r, out_beacon_r, out_status_r, out_flag_r, out_link_r;
  logic [CODE_W-1:0]     out_code_r;

  logic                  ch_chg, beacon, status, flag;
  logic                  in_fire;
  logic [TIMER_BITS-1:0] search_tk, answer_tk, standby_tk;
  logic                  search_exp, answer_exp, standby_exp;

  function automatic logic [TIMER_BITS-1:0] tick_cnt(input logic [TIMER_BITS-1:0] c,
                                                      input logic tick);
    logic [TIMER_BITS-1:0] r;
    r = c;
    if (tick && (c != '1)) begin
      r = c + TIMER_BITS'(1);
    end
    return r;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_ticks_r  <= SEARCH_TICKS_RST;
      answer_ticks_r  <= ANSWER_TICKS_RST;
      standby_ticks_r <= STANDBY_TICKS_RST;
      top_channel_r   <= TOP_CHANNEL_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_addr_t'(cfg_ch.addr))
        CFG_SEARCH_TICKS:  search_ticks_r  <= cfg_ch.data;
        CFG_ANSWER_TICKS:  answer_ticks_r  <= cfg_ch.data;
        CFG_STANDBY_TICKS: standby_ticks_r <= cfg_ch.data;
        CFG_TOP_CHANNEL:   top_channel_r   <= cfg_ch.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    search_tk   = tick_cnt(search_cnt_r, in_ch.time_tick);
    answer_tk   = tick_cnt(answer_cnt_r, in_ch.time_tick);
    standby_tk  = tick_cnt(standby_cnt_r, in_ch.time_tick);
    search_exp  = CMP_W'(search_tk)  >= CMP_W'(search_ticks_r);
    answer_exp  = CMP_W'(answer_tk)  >= CMP_W'(answer_ticks_r);
    standby_exp = CMP_W'(standby_tk) >= CMP_W'(standby_ticks_r);

    state_nxt       = state_r;
    chan_nxt        = chan_r;
    search_cnt_nxt  = search_tk;
    answer_cnt_nxt  = answer_tk;
    standby_cnt_nxt = standby_tk;
    last_line_nxt   = last_line_r;
    ch_chg          = 1'b0;
    beacon          = 1'b0;
    status          = 1'b0;
    flag            = 1'b0;

    unique case (state_r)
      ST_STANDBY: begin
        if (in_ch.line_level != last_line_r) begin
          status        = 1'b1;
          flag          = in_ch.line_level;
          last_line_nxt = in_ch.line_level;
          state_nxt     = ST_WAIT_TX;
        end else if (in_ch.rx_ready) begin
          if (in_ch.rx_checksum_ok) begin
            standby_cnt_nxt = '0;
            if (in_ch.rx_status_request) begin
              status        = 1'b1;
              flag          = in_ch.line_level;
              last_line_nxt = in_ch.line_level;
              state_nxt     = ST_WAIT_TX;
            end
          end
        end else if (standby_exp) begin
          state_nxt = ST_HOP;
        end
      end
      ST_WAIT_TX: begin
        if (!in_ch.tx_busy) begin
          state_nxt = ST_STANDBY;
        end
      end
      ST_PROBE: begin
        if (search_exp) begin
          state_nxt = ST_HOP;
        end else begin
          beacon    = 1'b1;
          state_nxt = ST_BEACON;
        end
      end
      ST_BEACON: begin
        if (!in_ch.tx_busy) begin
          answer_cnt_nxt = '0;
          state_nxt      = ST_WAIT_AN;
        end
      end
      ST_WAIT_AN: begin
        if (answer_exp) begin
          state_nxt = ST_PROBE;
        end else if (in_ch.rx_ready && in_ch.rx_checksum_ok) begin
          standby_cnt_nxt = '0;
          state_nxt       = ST_STANDBY;
        end
      end
      default: begin
        chan_nxt       = (chan_r < top_channel_r) ? chan_r + CHAN_W'(1) : '0;
        ch_chg         = 1'b1;
        search_cnt_nxt = '0;
        state_nxt      = ST_PROBE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_HOP;
      chan_r        <= '0;
      search_cnt_r  <= '0;
      answer_cnt_r  <= '0;
      standby_cnt_r <= '0;
      last_line_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r       <= state_nxt;
        chan_r        <= chan_nxt;
        search_cnt_r  <= search_cnt_nxt;
        answer_cnt_r  <= answer_cnt_nxt;
        standby_cnt_r <= standby_cnt_nxt;
        last_line_r   <= last_line_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_chan_r   <= chan_nxt;
      out_chg_r    <= ch_chg;
      out_beacon_r <= beacon;
      out_status_r <= status;
      out_flag_r   <= flag;
      out_link_r   <= (state_nxt == ST_STANDBY) || (state_nxt == ST_WAIT_TX);
      out_code_r   <= state_code(state_nxt);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.channel         = out_chan_r;
  assign out_ch.channel_changed = out_chg_r;
  assign out_ch.send_beacon     = out_beacon_r;
  assign out_ch.send_status     = out_status_r;
  assign out_ch.status_on_line  = out_flag_r;
  assign out_ch.link_up         = out_link_r;
  assign out_ch.fsm_state       = out_code_r;

  // Every accepted poll must leave a result in the output register.
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted poll produced no result");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state lost its one-hot code");

  a_beacon_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beacon_r) |-> (out_code_r == CODE_BEACON))
    else $error("beacon start outside the beacon state");

  a_hop_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chg_r) |-> (out_code_r == CODE_PROBE) && !out_link_r)
    else $error("channel change did not lead to the probe state");

  a_status_link: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_code_r == CODE_WAIT_TX) && out_link_r)
    else $error("status start did not lead to the wait state");

endmodule
`default_nettype wire
